@@ rtl/itk_pkg.sv @@
// Package for the tilt Kalman filter: fixed constants, arctangent table and lane types.
// No dependencies; used by every module of the block.
`default_nettype none
package itk_pkg;
  localparam int TabLen = 24;
  localparam logic signed [31:0] Deg180 = 32'sd5898240;
  localparam logic [31:0] ProcessNoiseReset = 32'd66;
  localparam logic [31:0] MeasureNoiseReset = 32'd196608;
  localparam logic [0:0] RegProcessNoise = 1'b0;
  localparam logic [0:0] RegMeasureNoise = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE, S_CORDIC, S_GAIN, S_DIV, S_UPD1, S_UPD2, S_OUT
  } itk_state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } itk_ctrl_t;

  function automatic logic [20:0] atan_entry(input logic [4:0] i);
    logic [20:0] r;
    case (i)
      5'd0: r = 21'd1474560;
      5'd1: r = 21'd870484;
      5'd2: r = 21'd459940;
      5'd3: r = 21'd233473;
      5'd4: r = 21'd117189;
      5'd5: r = 21'd58652;
      5'd6: r = 21'd29333;
      5'd7: r = 21'd14667;
      5'd8: r = 21'd7334;
      5'd9: r = 21'd3667;
      5'd10: r = 21'd1833;
      5'd11: r = 21'd917;
      5'd12: r = 21'd458;
      5'd13: r = 21'd229;
      5'd14: r = 21'd115;
      5'd15: r = 21'd57;
      5'd16: r = 21'd29;
      5'd17: r = 21'd14;
      5'd18: r = 21'd7;
      5'd19: r = 21'd4;
      5'd20: r = 21'd2;
      5'd21: r = 21'd1;
      default: r = 21'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] clamp_angle(input logic signed [39:0] v);
    if (v > 40'(Deg180)) return Deg180;
    if (v < -40'(Deg180)) return -Deg180;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

@@ rtl/itk_cordic.sv @@
// One CORDIC vectoring lane: atan2(y, x) in 1/32768 degree, one rotation per cycle.
// Depends on itk_pkg.
`default_nettype none
module itk_cordic #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire itk_pkg::itk_ctrl_t ctrl_in,
  input  wire logic signed [15:0] y_in,
  input  wire logic signed [15:0] x_in,
  output logic done,
  output logic signed [31:0] angle
);
  import itk_pkg::*;
  localparam int StepW = $clog2(CORDIC_STEPS + 1);

  logic signed [43:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic [StepW-1:0] step;
  logic running, zero_r;
  logic [4:0] idx;
  logic signed [43:0] xs, ys;
  logic signed [21:0] a;

  assign idx = 5'(step);
  assign xs = x_r >>> idx;
  assign ys = y_r >>> idx;
  assign a = $signed({1'b0, atan_entry(idx)});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl_in.start) begin
        running <= 1'b1;
        step <= '0;
      end else if (running) begin
        if (step == StepW'(CORDIC_STEPS - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_in.start) begin
      zero_r <= (x_in == 0) && (y_in == 0);
      if (x_in < 0) begin
        z_r <= (y_in >= 0) ? Deg180 : -Deg180;
        x_r <= -(44'(x_in) <<< 8);
        y_r <= -(44'(y_in) <<< 8);
      end else begin
        z_r <= '0;
        x_r <= 44'(x_in) <<< 8;
        y_r <= 44'(y_in) <<< 8;
      end
    end else if (running) begin
      if (y_r >= 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + 32'(a);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - 32'(a);
      end
    end
  end

  assign angle = zero_r ? '0 : clamp_angle(40'(z_r));
endmodule
`default_nettype wire

@@ rtl/itk_divider.sv @@
// Restoring divider: 49-bit numerator over 33-bit denominator, one quotient bit per cycle.
// Depends on itk_pkg.
`default_nettype none
module itk_divider (
  input  wire logic clk,
  input  wire logic rst,
  input  wire itk_pkg::itk_ctrl_t ctrl_in,
  input  wire logic [48:0] num,
  input  wire logic [32:0] den,
  output logic done,
  output logic [48:0] quot
);
  import itk_pkg::*;
  logic [48:0] q_r;
  logic [33:0] rem_r, trial;
  logic [32:0] den_r;
  logic [5:0] cnt;
  logic running;

  assign trial = {rem_r[32:0], q_r[48]};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl_in.start) begin
        running <= 1'b1;
        cnt <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == 6'd48) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl_in.start) begin
      q_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (running) begin
      if (trial >= {1'b0, den_r}) begin
        rem_r <= trial - {1'b0, den_r};
        q_r <= {q_r[47:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r <= {q_r[47:0], 1'b0};
      end
    end
  end

  assign quot = q_r;
endmodule
`default_nettype wire

@@ rtl/itk_lane.sv @@
// One axis lane: gyro prediction, variance, gain division and estimate update.
// Depends on itk_pkg and itk_divider.
`default_nettype none
module itk_lane (
  input  wire logic clk,
  input  wire logic rst,
  input  wire itk_pkg::itk_ctrl_t ctrl_in,
  input  wire logic signed [31:0] meas,
  input  wire logic signed [16:0] rate,
  input  wire logic [9:0] elapsed_ms,
  input  wire logic [31:0] process_noise,
  input  wire logic [31:0] measure_noise,
  output logic done,
  output logic signed [15:0] angle
);
  import itk_pkg::*;
  itk_state_t state, state_next;
  logic signed [31:0] estimate;
  logic [31:0] variance;
  logic [31:0] pn;
  logic [16:0] k;
  logic signed [39:0] pred;
  logic signed [40:0] diff;
  logic signed [58:0] prod;
  logic [48:0] vprod;
  logic signed [27:0] rms;
  itk_ctrl_t div_ctrl;
  logic div_done;
  logic [48:0] quot;
  logic [32:0] den;
  logic [48:0] num;
  logic [32:0] pn_sum;
  logic [27:0] mag, sixm;
  logic [56:0] recip;
  logic [21:0] dq;
  logic [26:0] dmag_r;
  logic signed [59:0] corr_mag;
  logic [57:0] pmag;

  assign pn_sum = 33'(variance) + 33'(process_noise);
  assign den = 33'(pn) + 33'(measure_noise);
  assign num = {pn, 16'd0} + 49'(den >> 1);

  assign div_ctrl = '{start: state == S_GAIN, busy: state == S_DIV, done: 1'b0};
  itk_divider u_div (.clk(clk), .rst(rst), .ctrl_in(div_ctrl), .num(num), .den(den),
    .done(div_done), .quot(quot));

  // round(256*m/125) = 2*m + floor((6*m + 62)/125), the last by reciprocal
  assign mag = rms[27] ? 28'(-rms) : 28'(rms);
  assign sixm = 28'({mag, 2'b00}) + 28'({mag, 1'b0}) + 28'd62;
  assign recip = 57'(sixm) * 57'(29'd274877907);
  assign dq = recip[56:35];
  assign pmag = prod[58] ? 58'(-prod) : 58'(prod[57:0]);
  assign corr_mag = 60'((pmag + 58'd32768) >> 16);

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (ctrl_in.start) state_next = S_CORDIC;
      S_CORDIC: if (ctrl_in.done) state_next = S_GAIN;
      S_GAIN: state_next = S_DIV;
      S_DIV: if (div_done) state_next = S_UPD1;
      S_UPD1: state_next = S_UPD2;
      S_UPD2: state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      estimate <= '0;
      variance <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (ctrl_in.start) begin
            rms <= 28'(rate) * 28'($signed({1'b0, elapsed_ms}));
            pn <= pn_sum[32] ? 32'hFFFF_FFFF : pn_sum[31:0];
          end
        end
        S_CORDIC: begin
          dmag_r <= 27'({mag, 1'b0}) + 27'(dq);
          pred <= 40'(estimate) + (rms[27] ? -40'(dmag_r) : 40'(dmag_r));
        end
        S_DIV: begin
          if (div_done) begin
            if (den == 0) k <= '0;
            else if (quot > 49'd65536) k <= 17'd65536;
            else k <= quot[16:0];
          end
        end
        S_UPD1: begin
          diff <= 41'(meas) - 41'(pred);
          vprod <= 49'(17'(17'd65536 - k)) * 49'(pn);
        end
        S_UPD2: begin
          prod <= 59'(diff) * $signed({1'b0, k});
          variance <= 32'((vprod + 49'd32768) >> 16);
        end
        S_OUT: begin
          estimate <= clamp_angle(pred + 40'(prod[58] ? -corr_mag : corr_mag));
          done <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  logic [31:0] emag;
  assign emag = estimate[31] ? 32'(-estimate) : estimate;
  assign angle = estimate[31] ? -16'((emag + 32'd128) >> 8) : 16'((emag + 32'd128) >> 8);

  assert property (@(posedge clk) disable iff (rst) done |-> $past(state) == S_OUT)
    else $error("lane done outside output step");
  assert property (@(posedge clk) disable iff (rst) state == S_UPD1 |-> k <= 17'd65536)
    else $error("gain above one");
  assert property (@(posedge clk) disable iff (rst)
      state == S_IDLE |-> (estimate <= Deg180 && estimate >= -Deg180))
    else $error("estimate out of range");
endmodule
`default_nettype wire

@@ rtl/imu_tilt_kalman_filter_core.sv @@
// Top level of the pitch/roll tilt Kalman filter.
// Depends on itk_pkg, itk_cordic, itk_lane.
`default_nettype none
// The result of an item is worked out by the CORDIC rotations and the 49-step
// bit-serial gain divider of each axis lane; the lanes run side by side. A new
// item is taken only once the result of the last has been loaded into the output
// register, which holds the result until taken while the next item is worked on.
module imu_tilt_kalman_filter_core #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_axis_tvalid,
  output logic s_axis_tready,
  // accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_ms, zero pad
  input  wire logic [95:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  wire logic m_axis_tready,
  // pitch_angle, roll_angle
  output logic [31:0] m_axis_tdata,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [31:0] cfg_data
);
  import itk_pkg::*;
  logic [31:0] process_noise, measure_noise;
  logic busy;
  logic pend;
  logic load;
  logic signed [15:0] ax, ay, az, gx, gy;
  logic [9:0] ms;
  itk_ctrl_t cstart, p_ctrl, r_ctrl;
  logic pc_done, rc_done, pl_done, rl_done;
  logic signed [31:0] p_meas, r_meas;
  logic signed [15:0] p_ang, r_ang;
  logic accept;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      process_noise <= ProcessNoiseReset;
      measure_noise <= MeasureNoiseReset;
    end else if (cfg_valid) begin
      if (cfg_index == RegProcessNoise) process_noise <= cfg_data;
      if (cfg_index == RegMeasureNoise) measure_noise <= cfg_data;
    end
  end

  assign s_axis_tready = !busy;
  assign accept = s_axis_tvalid && s_axis_tready;
  assign ax = s_axis_tdata[15:0];
  assign ay = s_axis_tdata[31:16];
  assign az = s_axis_tdata[47:32];
  assign gx = s_axis_tdata[63:48];
  assign gy = s_axis_tdata[79:64];
  assign ms = s_axis_tdata[89:80];

  assign cstart = '{start: accept, busy: busy, done: 1'b0};
  itk_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cp (.clk(clk), .rst(rst), .ctrl_in(cstart),
    .y_in(ax), .x_in(az), .done(pc_done), .angle(p_meas));
  itk_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cr (.clk(clk), .rst(rst), .ctrl_in(cstart),
    .y_in(ay), .x_in(az), .done(rc_done), .angle(r_meas));

  assign p_ctrl = '{start: accept, busy: busy, done: pc_done};
  assign r_ctrl = '{start: accept, busy: busy, done: rc_done};
  itk_lane u_lp (.clk(clk), .rst(rst), .ctrl_in(p_ctrl), .meas(p_meas),
    .rate(-17'(gy)), .elapsed_ms(ms), .process_noise(process_noise),
    .measure_noise(measure_noise), .done(pl_done), .angle(p_ang));
  itk_lane u_lr (.clk(clk), .rst(rst), .ctrl_in(r_ctrl), .meas(r_meas),
    .rate(17'(gx)), .elapsed_ms(ms), .process_noise(process_noise),
    .measure_noise(measure_noise), .done(rl_done), .angle(r_ang));

  assign load = (pl_done || pend) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (accept) busy <= 1'b1;
      if (load) begin
        busy <= 1'b0;
        pend <= 1'b0;
        m_axis_tvalid <= 1'b1;
      end else begin
        if (pl_done) pend <= 1'b1;
        if (m_axis_tready) m_axis_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) m_axis_tdata <= {r_ang, p_ang};
  end

  assert property (@(posedge clk) disable iff (rst) pl_done == rl_done)
    else $error("lanes out of step");
  assert property (@(posedge clk) disable iff (rst) pl_done |-> busy && !pend)
    else $error("result with no item in flight");
  assert property (@(posedge clk) disable iff (rst) pend |-> m_axis_tvalid)
    else $error("result held with output free");
  assert property (@(posedge clk) disable iff (rst) accept |=> busy)
    else $error("accepted item not taken up");
endmodule
`default_nettype wire

@@ verif/tb.sv @@
// Testbench for imu_tilt_kalman_filter_core: drives IMU samples and noise settings,
// predicts filtered pitch and roll per item and checks each result. Depends on itk_pkg.
`timescale 1ns / 100ps

class tilt_scoreboard;
  bit [31:0] q_noise;
  bit [31:0] r_noise;
  longint pitch_est, roll_est;
  longint unsigned pitch_var, roll_var;
  bit [31:0] angle_queue[$];
  int errors;

  function new();
    reset_state();
  endfunction

  function void reset_state();
    q_noise = itk_pkg::ProcessNoiseReset;
    r_noise = itk_pkg::MeasureNoiseReset;
    pitch_est = 0;
    roll_est = 0;
    pitch_var = 0;
    roll_var = 0;
    angle_queue.delete();
  endfunction

  function longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function longint round_div(longint v, longint d);
    longint m;
    longint q;
    m = v < 0 ? -v : v;
    q = (m + d / 2) / d;
    return v < 0 ? -q : q;
  endfunction

  function longint clamp(longint v);
    if (v > 5898240) return 5898240;
    if (v < -5898240) return -5898240;
    return v;
  endfunction

  function longint tilt_atan2(longint y, longint x);
    longint z, nx, ny;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? 5898240 : -5898240;
      x = -x;
      y = -y;
    end
    x = x * 256;
    y = y * 256;
    for (int i = 0; i < 16; i++) begin
      if (y >= 0) begin
        nx = x + floor_shift(y, i);
        ny = y - floor_shift(x, i);
        z = z + longint'(itk_pkg::atan_entry(i[4:0]));
      end else begin
        nx = x - floor_shift(y, i);
        ny = y + floor_shift(x, i);
        z = z - longint'(itk_pkg::atan_entry(i[4:0]));
      end
      x = nx;
      y = ny;
    end
    return clamp(z);
  endfunction

  function longint update_axis(longint est, ref longint unsigned var_q, longint delta,
                               longint meas);
    longint unsigned pn, den, k;
    longint pred;
    pn = var_q + q_noise;
    if (pn > 64'hFFFF_FFFF) pn = 64'hFFFF_FFFF;
    den = pn + r_noise;
    k = den != 0 ? (pn * 65536 + den / 2) / den : 0;
    if (k > 65536) k = 65536;
    pred = est + delta;
    var_q = ((65536 - k) * pn + 32768) / 65536;
    var_q = var_q & 64'hFFFF_FFFF;
    return clamp(pred + round_div((meas - pred) * longint'(k), 65536));
  endfunction

  function void note_sample(bit [95:0] d);
    longint ax, ay, az, gx, gy, ms;
    longint p_out, r_out;
    ax = longint'($signed(d[15:0]));
    ay = longint'($signed(d[31:16]));
    az = longint'($signed(d[47:32]));
    gx = longint'($signed(d[63:48]));
    gy = longint'($signed(d[79:64]));
    ms = longint'(d[89:80]);
    pitch_est = update_axis(pitch_est, pitch_var, round_div(-gy * ms * 256, 125),
                            tilt_atan2(ax, az));
    roll_est = update_axis(roll_est, roll_var, round_div(gx * ms * 256, 125),
                           tilt_atan2(ay, az));
    p_out = round_div(pitch_est, 256);
    r_out = round_div(roll_est, 256);
    angle_queue.push_back({r_out[15:0], p_out[15:0]});
  endfunction

  task report(string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  task check_angles(bit [31:0] got);
    bit [31:0] want;
    if (angle_queue.size() == 0) begin
      report($sformatf("unexpected item %h", got));
      return;
    end
    want = angle_queue.pop_front();
    if (got[15:0] != want[15:0])
      report($sformatf("pitch got %0d want %0d", $signed(got[15:0]), $signed(want[15:0])));
    if (got[31:16] != want[31:16])
      report($sformatf("roll got %0d want %0d", $signed(got[31:16]), $signed(want[31:16])));
  endtask
endclass

module tb;
  import itk_pkg::*;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [31:0] cfg_data;

  tilt_scoreboard board;
  bit hold_off;
  bit stall_en;

  imu_tilt_kalman_filter_core uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 200);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 4);
  endfunction

  task automatic send_sample(bit [95:0] d);
    int g;
    g = stall_en ? gap_len() : 0;
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk); while (!s_axis_tready);
    board.note_sample(d);
  endtask

  task automatic write_reg(logic [0:0] idx, bit [31:0] val);
    s_axis_tvalid <= 1'b0;
    while (board.angle_queue.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == RegProcessNoise) board.q_noise = val;
    else board.r_noise = val;
  endtask

  function automatic bit [95:0] pack_sample(bit [15:0] ax, bit [15:0] ay, bit [15:0] az,
                                            bit [15:0] gx, bit [15:0] gy, bit [9:0] ms);
    return {6'b0, ms, gy, gx, az, ay, ax};
  endfunction

  function automatic bit [95:0] random_sample(bit tame);
    bit [15:0] ax, ay, az, gx, gy;
    bit [9:0] ms;
    if (tame) begin
      ax = 16'($signed($urandom_range(0, 8000)) - 4000);
      ay = 16'($signed($urandom_range(0, 8000)) - 4000);
      az = 16'($signed($urandom_range(0, 20000)) - 4000);
      gx = 16'($signed($urandom_range(0, 4000)) - 2000);
      gy = 16'($signed($urandom_range(0, 4000)) - 2000);
      ms = 10'($urandom_range(1, 20));
    end else begin
      ax = 16'($urandom);
      ay = 16'($urandom);
      az = 16'($urandom);
      gx = 16'($urandom);
      gy = 16'($urandom);
      ms = 10'($urandom);
    end
    return pack_sample(ax, ay, az, gx, gy, ms);
  endfunction

  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) board.check_angles(m_axis_tdata);
    if (hold_off) m_axis_tready <= 1'b0;
    else if (!stall_en) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 19) == 0) ? 1'b0 : ($urandom_range(0, 3) != 0);
  end

  task automatic random_phase(int n);
    for (int i = 0; i < n; i++) send_sample(random_sample($urandom_range(0, 9) != 0));
  endtask

  initial begin
    board = new();
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = RegProcessNoise;
    cfg_data = '0;
    hold_off = 1'b0;
    stall_en = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_sample(pack_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0));
    send_sample(pack_sample(16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 16'h8000, 10'd1000));
    send_sample(pack_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 10'd1023));
    send_sample(pack_sample(16'd0, 16'd0, 16'h8000, 16'd0, 16'd0, 10'd5));
    send_sample(pack_sample(16'hFFFF, 16'd1, 16'hFFFF, 16'd16, 16'hFFF0, 10'd10));
    send_sample(pack_sample(16'd100, 16'hFF9C, 16'd4000, 16'h7FFF, 16'h7FFF, 10'd1023));
    send_sample(pack_sample(16'd0, 16'd0, 16'd1, 16'h8000, 16'h8000, 10'd1023));
    send_sample(pack_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 10'h3FF));
    send_sample(pack_sample(16'd0, 16'd0, 16'd0, 16'd1, 16'd1, 10'd1));

    write_reg(RegMeasureNoise, 32'd0);
    write_reg(RegProcessNoise, 32'd0);
    send_sample(pack_sample(16'd500, 16'd500, 16'd1000, 16'd0, 16'd0, 10'd1));
    send_sample(pack_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 10'd0));
    write_reg(RegProcessNoise, 32'hFFFF_FFFF);
    write_reg(RegMeasureNoise, 32'hFFFF_FFFF);
    send_sample(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h1000, 16'h1000, 10'd100));
    send_sample(pack_sample(16'h8000, 16'h8000, 16'h7FFF, 16'h1000, 16'h1000, 10'd100));

    stall_en = 1'b1;
    write_reg(RegProcessNoise, ProcessNoiseReset);
    write_reg(RegMeasureNoise, MeasureNoiseReset);
    random_phase(500);

    hold_off = 1'b1;
    fork
      begin
        repeat (600) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(6);
    join

    write_reg(RegProcessNoise, 32'd65536);
    write_reg(RegMeasureNoise, 32'd1);
    random_phase(350);
    write_reg(RegProcessNoise, $urandom);
    write_reg(RegMeasureNoise, $urandom | 32'd1);
    random_phase(350);
    write_reg(RegProcessNoise, 32'hFFFF_FFFF);
    write_reg(RegMeasureNoise, 32'd65536);
    random_phase(200);
    write_reg(RegProcessNoise, 32'd0);
    write_reg(RegMeasureNoise, 32'hFFFF_FFFF);
    random_phase(230);

    s_axis_tvalid <= 1'b0;
    while (board.angle_queue.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.angle_queue.size() == 0 && board.errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #50ms;
    $display("Simulation FAILED");
    $finish;
  end
endmodule

@@ imu_tilt_kalman_filter_core.f @@
rtl/itk_pkg.sv
rtl/itk_cordic.sv
rtl/itk_divider.sv
rtl/itk_lane.sv
rtl/imu_tilt_kalman_filter_core.sv
verif/tb.sv
